// File: src/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Types, character codes and decode helpers for the C string escape decoder.
// ----------------------------------------------------------------------------
package cse_pkg;

  // Scanner state
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } scan_mode_t;

  // One queued result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } res_entry_t;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  // Simple escape: bit 8 set when c names one, bits 7:0 give the byte
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h6E:     r = {1'b1, 8'd10};  // n
      8'h74:     r = {1'b1, 8'd9};   // t
      8'h76:     r = {1'b1, 8'd11};  // v
      8'h62:     r = {1'b1, 8'd8};   // b
      8'h72:     r = {1'b1, 8'd13};  // r
      8'h66:     r = {1'b1, 8'd12};  // f
      8'h61:     r = {1'b1, 8'd7};   // a
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_QMARK:  r = {1'b1, CH_QMARK};
      CH_SQUOTE: r = {1'b1, CH_SQUOTE};
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  // Decimal digit test
  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Hex digit: bit 4 set when c is one, bits 3:0 give its value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: src/cse_in_if.sv
// ----------------------------------------------------------------------------
// cse_in_if
// Input channel: one literal byte per item with its last-byte mark.
// ----------------------------------------------------------------------------
interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       final_char;

  modport source (output valid, output char_in, output final_char, input ready);
  modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

// File: src/cse_out_if.sv
// ----------------------------------------------------------------------------
// cse_out_if
// Output channel: one unescaped byte per item with its end-of-run mark.
// ----------------------------------------------------------------------------
interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// File: src/c_string_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// c_string_escape_decoder_top
// Unescapes the interior bytes of a C string literal, one byte per item.
// ----------------------------------------------------------------------------
//  channel | dir | payload               | handshake
//  din     | in  | char_in, final_char   | valid/ready
//  dout    | out | out_byte, run_last    | valid/ready
//
//  One input item per cycle while din.ready is high; each item is decoded
//  in the cycle it is taken and its 0..2 results are written to a 4-entry
//  result queue, one slot per result. Results leave one per cycle while
//  dout.ready is high; din.ready drops while fewer than two slots are free.
//  Reset (rst, synchronous) empties the queue and returns to plain mode.
// ----------------------------------------------------------------------------
module c_string_escape_decoder_top
  import cse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cse_in_if.sink     din,
  cse_out_if.source  dout
);

  // Scanner state
  scan_mode_t mode, mode_next;
  logic [7:0] value, value_next;

  // Results of the current item
  logic [1:0] n_res;
  logic [7:0] res0, res1;

  // Result queue
  res_entry_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic [7:0] c;
  logic       take_plain;
  logic [8:0] simple;
  logic [4:0] hexv;
  logic       accept, pop;

  assign c      = din.char_in;
  assign simple = simple_escape(c);
  assign hexv   = hex_val(c);
  assign accept = din.valid && din.ready;
  assign pop    = dout.valid && dout.ready;

  // Decode one byte against the current state
  always_comb begin
    mode_next  = mode;
    value_next = value;
    n_res      = 2'd0;
    res0       = 8'd0;
    res1       = 8'd0;
    take_plain = 1'b0;

    unique case (mode)
      MODE_PLAIN: begin
        take_plain = 1'b1;
      end
      MODE_ESC: begin
        if (simple[8]) begin
          res0      = simple[7:0];
          n_res     = 2'd1;
          mode_next = MODE_PLAIN;
        end else if (is_dec(c)) begin
          mode_next  = MODE_OCT;
          value_next = {4'd0, c[3:0]};
        end else if (c == CH_X) begin
          mode_next  = MODE_HEX;
          value_next = 8'd0;
        end else begin
          mode_next = MODE_PLAIN;
        end
      end
      MODE_OCT: begin
        if (is_dec(c)) begin
          value_next = {value[4:0], 3'b000} + {4'd0, c[3:0]};
        end else begin
          res0       = value;
          n_res      = 2'd1;
          mode_next  = MODE_PLAIN;
          value_next = 8'd0;
          take_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hexv[4]) begin
          value_next = {value[3:0], hexv[3:0]};
        end else begin
          res0       = value;
          n_res      = 2'd1;
          mode_next  = MODE_PLAIN;
          value_next = 8'd0;
          take_plain = 1'b1;
        end
      end
      default: ;
    endcase

    // Byte seen in plain mode
    if (take_plain) begin
      if (c == CH_BSLASH) begin
        mode_next = MODE_ESC;
      end else if (c != CH_DQUOTE) begin
        if (n_res == 2'd0) res0 = c;
        else               res1 = c;
        n_res = n_res + 2'd1;
      end
    end

    // Last byte: flush a pending numeric escape, then reset
    if (din.final_char) begin
      if (mode_next == MODE_OCT || mode_next == MODE_HEX) begin
        if (n_res == 2'd0) res0 = value_next;
        else               res1 = value_next;
        n_res = n_res + 2'd1;
      end
      mode_next  = MODE_PLAIN;
      value_next = 8'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      value <= 8'd0;
    end else if (accept) begin
      mode  <= mode_next;
      value <= value_next;
    end
  end

  // Result queue write
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      mem[wr_ptr] <= '{out_byte: res0, run_last: (n_res == 2'd1)};
      if (n_res == 2'd2) begin
        mem[wr_ptr + 2'd1] <= '{out_byte: res1, run_last: 1'b1};
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + n_res;
      if (pop)    rd_ptr <= rd_ptr + 2'd1;
      count <= count + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end

  assign din.ready     = (count <= 3'd2);
  assign dout.valid    = (count != 3'd0);
  assign dout.out_byte = mem[rd_ptr].out_byte;
  assign dout.run_last = mem[rd_ptr].run_last;

endmodule
